// ----- rtl/jts_pkg.sv -----
// ----------------------------------------------------------------------------
// jts_pkg
// Word types, command codes and status codes of the joint trajectory block.
// ----------------------------------------------------------------------------
package jts_pkg;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] ST_MOVING = 2'd0;
    localparam logic [1:0] ST_FINAL  = 2'd1;
    localparam logic [1:0] ST_IDLE   = 2'd2;

    localparam logic [1:0] ADDR_JOINT_COUNT = 2'd0;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [2:0]         joint_index;
        logic signed [31:0] start_pos;
        logic signed [31:0] end_pos;
        logic               is_linear;
        logic [31:0]        duration;
        logic [31:0]        time_step;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         out_joint;
        logic signed [31:0] position;
        logic [1:0]         status;
        logic               last;
    } t_out_word;

endpackage

// ----- rtl/joint_trajectory_smoothstep.sv -----
// ----------------------------------------------------------------------------
// joint_trajectory_smoothstep
// Multi-joint move generator with smoothstep easing, bit-serial datapath.
// ----------------------------------------------------------------------------
// Load and start words are taken in the idle state, which they do not
// leave. A tick during a move runs a restoring divider, two shift-add
// multiplies for the easing curve (each followed by a rounding step), then
// for each joint a table read and a difference step, a revolute wrap
// reduction (skipped for linear joints), one shift-add multiply, one
// rounding step and one step to register the joint's result word. The
// final sample skips the per-joint arithmetic and goes from the difference
// step straight to the result word. An output stall holds the block at
// each result word until the output is free. An idle tick returns one word
// through the S_IDLE_OUT state, which also waits for a free output.
module joint_trajectory_smoothstep
    import jts_pkg::*;
#(
    parameter int MAX_JOINTS = 8,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_word    i_in_word,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_word   o_out_word,
    input  logic        i_out_stall,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NJ  = (MAX_JOINTS < 8) ? MAX_JOINTS : 8;
    localparam int IW  = (NJ > 1) ? $clog2(NJ) : 1;
    localparam int QW  = FRAC_BITS + 1;
    localparam int MB  = FRAC_BITS + 2;
    localparam int AW  = 35;
    localparam int PW  = AW + MB;
    localparam int YW  = 37;
    localparam int CW  = 6;
    localparam int WRAP_K = 32 - FRAC_BITS;

    localparam logic [31:0] MIN_DUR =
        32'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [63:0] PI_Q =
        (64'd13493037705 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic [YW-1:0] PI_Y     = YW'(PI_Q);
    localparam logic [YW-1:0] TWO_PI_Y = YW'(PI_Q << 1);
    localparam logic [QW-1:0] ONE_Q    = QW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] HALF_P   = PW'(1) << (FRAC_BITS - 1);
    localparam logic [MB-1:0] THREE_Q  = MB'(3) << FRAC_BITS;

    localparam logic [CW-1:0] DIV_LAST  = CW'(FRAC_BITS);
    localparam logic [CW-1:0] MUL_LAST  = CW'(MB - 1);
    localparam logic [CW-1:0] WRAP_LAST = CW'(WRAP_K + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_IDLE_OUT, S_DIV, S_MUL, S_POST, S_LOAD, S_DIFF, S_WRAP, S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_T2, PH_U, PH_POS
    } t_phase;

    // Joint tables.
    logic [31:0] r_start_mem [NJ];
    logic [31:0] r_end_mem   [NJ];
    logic        r_lin_mem   [NJ];

    t_state             r_state;
    t_phase             r_phase;
    logic [3:0]         r_joint_count;
    logic [31:0]        r_elapsed;
    logic [31:0]        r_duration;
    logic               r_active;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [32:0]        r_rem;
    logic [QW-1:0]      r_q;
    logic [QW-1:0]      r_u;
    logic signed [PW-1:0] r_ma;
    logic [MB-1:0]      r_mb;
    logic signed [PW-1:0] r_acc;
    logic [YW-1:0]      r_y;
    logic [YW-1:0]      r_dv;
    logic [2:0]         r_j;
    logic signed [31:0] r_s;
    logic signed [31:0] r_e;
    logic               r_lin;
    logic signed [AW-1:0] r_r;
    logic               r_ov;
    t_out_word          r_ow;

    logic        cfg_wr;
    logic        in_acc;
    logic        out_free;
    logic        emit_now;
    logic [32:0] n_sum;
    logic [31:0] n_elapsed;
    logic [32:0] div_trial;
    logic        div_ge;
    logic [3:0]  n_eff;
    logic        is_last;
    logic signed [33:0] diff_raw;
    logic [PW-1:0] t2_full;
    logic [PW-1:0] u_full;
    logic [PW-1:0] p_mag;
    logic [PW-1:0] p_rnd;
    logic signed [AW-1:0] pos_sum;
    logic signed [31:0] pos_sat;
    logic [IW-1:0] rd_idx;

    assign pready   = 1'b1;
    assign prdata   = {28'd0, r_joint_count};
    assign cfg_wr   = psel && penable && pwrite && (paddr == ADDR_JOINT_COUNT);
    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_ov || !i_out_stall;
    assign emit_now = out_free && (r_state == S_EMIT || r_state == S_IDLE_OUT);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_word  = r_ow;

    assign n_sum     = {1'b0, r_elapsed} + {1'b0, i_in_word.time_step};
    assign n_elapsed = n_sum[32] ? 32'hFFFF_FFFF : n_sum[31:0];

    // First divider step compares without the shift.
    assign div_trial = (r_cnt == '0) ? r_rem : {r_rem[31:0], 1'b0};
    assign div_ge    = div_trial >= {1'b0, r_duration};

    always_comb begin
        if (r_joint_count == 4'd0) begin
            n_eff = 4'd1;
        end else if (32'(r_joint_count) > NJ) begin
            n_eff = 4'(NJ);
        end else begin
            n_eff = r_joint_count;
        end
    end
    assign is_last = ({1'b0, r_j} == (n_eff - 4'd1));

    assign diff_raw  = 34'(r_e) - 34'(r_s);

    assign t2_full = (r_acc + HALF_P) >> FRAC_BITS;
    assign u_full  = (r_acc + HALF_P) >> FRAC_BITS;
    assign p_mag   = r_acc[PW-1] ? PW'(-r_acc) : PW'(r_acc);
    assign p_rnd   = (p_mag + HALF_P) >> FRAC_BITS;

    assign pos_sum = AW'(r_s) + r_r;
    always_comb begin
        if (pos_sum > AW'(32'sh7FFF_FFFF)) begin
            pos_sat = 32'sh7FFF_FFFF;
        end else if (pos_sum < -AW'(64'sh8000_0000)) begin
            pos_sat = 32'sh8000_0000;
        end else begin
            pos_sat = pos_sum[31:0];
        end
    end

    assign rd_idx = IW'(r_j);

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_word.cmd == CMD_LOAD
                && 32'(i_in_word.joint_index) < NJ) begin
            r_start_mem[IW'(i_in_word.joint_index)] <= i_in_word.start_pos;
            r_end_mem[IW'(i_in_word.joint_index)]   <= i_in_word.end_pos;
            r_lin_mem[IW'(i_in_word.joint_index)]   <= i_in_word.is_linear;
        end
        if (r_state == S_LOAD) begin
            r_s   <= r_start_mem[rd_idx];
            r_e   <= r_end_mem[rd_idx];
            r_lin <= r_lin_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= PH_T2;
            r_joint_count <= 4'd6;
            r_elapsed     <= '0;
            r_duration    <= MIN_DUR;
            r_active      <= 1'b0;
            r_ov          <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_joint_count <= pwdata[3:0];
            end
            if (emit_now) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in_word.cmd)
                            CMD_START: begin
                                r_duration <= (i_in_word.duration < MIN_DUR) ?
                                              MIN_DUR : i_in_word.duration;
                                r_elapsed  <= '0;
                                r_active   <= 1'b1;
                            end
                            CMD_TICK: begin
                                if (!r_active) begin
                                    r_state <= S_IDLE_OUT;
                                end else begin
                                    r_elapsed <= n_elapsed;
                                    r_done    <= n_elapsed >= r_duration;
                                    r_rem     <= {1'b0, (n_elapsed < r_duration) ?
                                                        n_elapsed : r_duration};
                                    r_q       <= '0;
                                    r_cnt     <= '0;
                                    r_state   <= S_DIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                S_IDLE_OUT: begin
                    if (out_free) begin
                        r_ow.out_joint <= 3'd0;
                        r_ow.position  <= '0;
                        r_ow.status    <= ST_IDLE;
                        r_ow.last      <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end

                S_DIV: begin
                    r_rem <= div_ge ? (div_trial - {1'b0, r_duration}) : div_trial;
                    r_q   <= {r_q[QW-2:0], div_ge};
                    if (r_cnt == DIV_LAST) begin
                        r_cnt   <= '0;
                        r_phase <= PH_T2;
                        r_ma    <= PW'(r_q[QW-2:0]) << 1 | PW'(div_ge);
                        r_mb    <= MB'({r_q[QW-2:0], div_ge});
                        r_acc   <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end

                S_MUL: begin
                    if (r_mb[0]) begin
                        r_acc <= r_acc + r_ma;
                    end
                    r_ma  <= r_ma <<< 1;
                    r_mb  <= r_mb >> 1;
                    if (r_cnt == MUL_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_POST;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end

                S_POST: begin
                    unique case (r_phase)
                        PH_T2: begin
                            r_phase <= PH_U;
                            r_ma    <= t2_full;
                            r_mb    <= THREE_Q - (MB'(r_q) << 1);
                            r_acc   <= '0;
                            r_state <= S_MUL;
                        end
                        PH_U: begin
                            r_u     <= (u_full > PW'(ONE_Q)) ? ONE_Q : QW'(u_full);
                            r_j     <= '0;
                            r_state <= S_LOAD;
                        end
                        default: begin
                            r_r     <= r_acc[PW-1] ? -AW'(p_rnd) : AW'(p_rnd);
                            r_state <= S_EMIT;
                        end
                    endcase
                end

                S_LOAD: begin
                    r_state <= S_DIFF;
                end

                S_DIFF: begin
                    r_acc <= '0;
                    r_cnt <= '0;
                    if (r_done) begin
                        r_state <= S_EMIT;
                    end else if (r_lin) begin
                        r_phase <= PH_POS;
                        r_ma    <= PW'(diff_raw);
                        r_mb    <= MB'(r_u);
                        r_state <= S_MUL;
                    end else begin
                        // Offset by a large multiple of two pi so the
                        // reduction only ever sees a positive value.
                        r_y     <= YW'(diff_raw) + PI_Y + (TWO_PI_Y << WRAP_K);
                        r_dv    <= TWO_PI_Y << (WRAP_K + 1);
                        r_state <= S_WRAP;
                    end
                end

                S_WRAP: begin
                    if (r_y >= r_dv) begin
                        r_y <= r_y - r_dv;
                    end
                    r_dv <= r_dv >> 1;
                    if (r_cnt == WRAP_LAST) begin
                        // Wrapped difference feeds the multiplier.
                        r_cnt   <= '0;
                        r_phase <= PH_POS;
                        r_ma    <= PW'($signed(34'(((r_y >= r_dv) ? (r_y - r_dv) : r_y)
                                                   - PI_Y)));
                        r_mb    <= MB'(r_u);
                        r_acc   <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end

                S_EMIT: begin
                    if (out_free) begin
                        r_ow.out_joint <= r_j;
                        r_ow.position  <= r_done ? r_e : pos_sat;
                        r_ow.status    <= r_done ? ST_FINAL : ST_MOVING;
                        r_ow.last      <= is_last;
                        if (is_last) begin
                            if (r_done) begin
                                r_active <= 1'b0;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + 3'd1;
                            r_state <= S_LOAD;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- test/joint_trajectory_smoothstep_test.sv -----
// ----------------------------------------------------------------------------
// joint_trajectory_smoothstep_test
// Drives load, start and tick words into the move generator with random
// bursts and output stalls, predicts every result word in fixed point and
// compares each word field by field, across several joint counts.
// ----------------------------------------------------------------------------
module joint_trajectory_smoothstep_test;
    import jts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         NJ       = 8;
    localparam int         FB       = 16;
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int         CYC_MAX  = 1000000;
    localparam logic [31:0] MIN_DUR = 32'd3277;
    localparam longint     PI_FX    = 205887;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    t_in_word    i_in_word;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_word   o_out_word;
    logic        i_out_stall;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    joint_trajectory_smoothstep uut (.*);

    // Predictor state.
    logic [31:0] pos_a [NJ];
    logic [31:0] pos_b [NJ];
    logic        lin_f [NJ];
    logic [31:0] elapsed;
    logic [31:0] dur;
    logic        moving;
    logic [3:0]  jcnt;

    t_out_word   pending_words[$];
    int          n_err;
    int          cyc;
    logic        stall_mode;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_MAX) begin
            $display("FAIL joint_trajectory_smoothstep");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cyc);
        n_err++;
    endtask

    function automatic longint wrap_angle(input longint d);
        longint r;
        r = (d + PI_FX) % (2 * PI_FX);
        if (r < 0) r += 2 * PI_FX;
        return r - PI_FX;
    endfunction

    function automatic longint ease_curve();
        longint el, t, t2, u;
        el = (elapsed < dur) ? elapsed : dur;
        t = (el << FB) / dur;
        if (t > (1 << FB)) t = 1 << FB;
        t2 = (t * t + (1 << (FB - 1))) >>> FB;
        u = (t2 * (3 * (1 << FB) - 2 * t) + (1 << (FB - 1))) >>> FB;
        return (u > (1 << FB)) ? (1 << FB) : u;
    endfunction

    task automatic predict_word(input t_in_word w);
        longint s0, e0, d, p, m, r, u, v;
        logic [33:0] sum;
        int n;
        logic fin;
        t_out_word o;
        case (w.cmd)
            CMD_LOAD: begin
                pos_a[w.joint_index] = w.start_pos;
                pos_b[w.joint_index] = w.end_pos;
                lin_f[w.joint_index] = w.is_linear;
            end
            CMD_START: begin
                dur = (w.duration < MIN_DUR) ? MIN_DUR : w.duration;
                elapsed = '0;
                moving = 1'b1;
            end
            CMD_TICK: begin
                if (!moving) begin
                    o = '{out_joint: 3'd0, position: 32'sd0, status: ST_IDLE, last: 1'b1};
                    pending_words.push_back(o);
                end else begin
                    sum = {2'b0, elapsed} + {2'b0, w.time_step};
                    elapsed = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    fin = (elapsed >= dur);
                    u = ease_curve();
                    n = (jcnt < 1) ? 1 : ((jcnt > NJ) ? NJ : jcnt);
                    for (int i = 0; i < n; i++) begin
                        s0 = $signed(pos_a[i]);
                        e0 = $signed(pos_b[i]);
                        o.out_joint = i[2:0];
                        o.status = fin ? ST_FINAL : ST_MOVING;
                        o.last = (i == n - 1);
                        if (fin) begin
                            o.position = pos_b[i];
                        end else begin
                            d = e0 - s0;
                            if (!lin_f[i]) d = wrap_angle(d);
                            p = d * u;
                            m = (p < 0) ? -p : p;
                            r = (m + (1 << (FB - 1))) >>> FB;
                            v = s0 + ((p < 0) ? -r : r);
                            if (v > 64'sd2147483647) v = 64'sd2147483647;
                            if (v < -64'sd2147483648) v = -64'sd2147483648;
                            o.position = v[31:0];
                        end
                        pending_words.push_back(o);
                    end
                    if (fin) moving = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    // Result checker with its own stall pattern.
    always @(posedge i_clk) begin
        t_out_word w;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_words.size() == 0) begin
                    report("unexpected word", o_out_word.position, 0);
                end else begin
                    w = pending_words.pop_front();
                    if (o_out_word.out_joint !== w.out_joint)
                        report("out_joint", o_out_word.out_joint, w.out_joint);
                    if (o_out_word.position !== w.position)
                        report("position", o_out_word.position, w.position);
                    if (o_out_word.status !== w.status)
                        report("status", o_out_word.status, w.status);
                    if (o_out_word.last !== w.last)
                        report("last", o_out_word.last, w.last);
                end
            end
            if (stall_mode)
                i_out_stall <= ($urandom_range(0, 3) == 0);
            else
                i_out_stall <= 1'b0;
        end
    end

    task automatic apb_write(input logic [1:0] a, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_joints(input logic [3:0] n);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        apb_write(ADDR_JOINT_COUNT, {28'd0, n});
        jcnt = n;
    endtask

    // Sends one word; waits until it is accepted, then predicts.
    task automatic send_word(input t_in_word w);
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_word(w);
        if ($urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic t_in_word mk(input logic [1:0] c, input logic [2:0] j,
                                    input logic [31:0] a, input logic [31:0] b,
                                    input logic l, input logic [31:0] d,
                                    input logic [31:0] s);
        t_in_word w;
        w.cmd = c; w.joint_index = j; w.start_pos = a; w.end_pos = b;
        w.is_linear = l; w.duration = d; w.time_step = s;
        return w;
    endfunction

    function automatic logic [31:0] rnd_pos();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom)};
            2: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    function automatic logic [31:0] rnd_time();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 4000);
            default: return $urandom_range(1000, 80000);
        endcase
    endfunction

    t_in_word dir_rows[$];

    initial begin
        t_in_word w;
        int n;
        cyc = 0;
        n_err = 0;
        stall_mode = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        elapsed = '0;
        dur = MIN_DUR;
        moving = 1'b0;
        jcnt = 4'd6;
        for (int i = 0; i < NJ; i++) begin
            pos_a[i] = '0; pos_b[i] = '0; lin_f[i] = 1'b0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: idle tick, extreme loads, floored duration, saturation.
        dir_rows.push_back(mk(CMD_TICK, 3'd0, 0, 0, 1'b0, 0, 32'd100));
        dir_rows.push_back(mk(CMD_NONE, 3'd7, 32'h1234, 32'h5678, 1'b1, 5, 5));
        dir_rows.push_back(mk(CMD_LOAD, 3'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 0, 0));
        dir_rows.push_back(mk(CMD_LOAD, 3'd1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 0, 0));
        dir_rows.push_back(mk(CMD_LOAD, 3'd2, 32'h7FFF_0000, 32'h8001_0000, 1'b0, 0, 0));
        dir_rows.push_back(mk(CMD_LOAD, 3'd3, 32'h0, 32'h0003_2400, 1'b0, 0, 0));
        dir_rows.push_back(mk(CMD_LOAD, 3'd4, 32'hFFFF_0000, 32'h0001_0000, 1'b1, 0, 0));
        dir_rows.push_back(mk(CMD_LOAD, 3'd5, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 0, 0));
        dir_rows.push_back(mk(CMD_LOAD, 3'd6, 32'hFFFF_FFFF, 32'h0, 1'b1, 0, 0));
        dir_rows.push_back(mk(CMD_LOAD, 3'd7, 32'h0, 32'hFFFC_DC00, 1'b0, 0, 0));
        dir_rows.push_back(mk(CMD_START, 3'd0, 0, 0, 1'b0, 32'd0, 0));
        dir_rows.push_back(mk(CMD_TICK, 3'd0, 0, 0, 1'b0, 0, 32'd0));
        dir_rows.push_back(mk(CMD_TICK, 3'd0, 0, 0, 1'b0, 0, 32'd1000));
        dir_rows.push_back(mk(CMD_TICK, 3'd0, 0, 0, 1'b0, 0, 32'd5000));
        dir_rows.push_back(mk(CMD_TICK, 3'd0, 0, 0, 1'b0, 0, 32'd1));
        dir_rows.push_back(mk(CMD_START, 3'd0, 0, 0, 1'b0, 32'hFFFF_FFFF, 0));
        dir_rows.push_back(mk(CMD_TICK, 3'd0, 0, 0, 1'b0, 0, 32'h8000_0000));
        dir_rows.push_back(mk(CMD_TICK, 3'd0, 0, 0, 1'b0, 0, 32'hFFFF_FFFF));
        dir_rows.push_back(mk(CMD_START, 3'd0, 0, 0, 1'b0, 32'd3276, 0));
        dir_rows.push_back(mk(CMD_TICK, 3'd0, 0, 0, 1'b0, 0, 32'd1638));
        dir_rows.push_back(mk(CMD_TICK, 3'd0, 0, 0, 1'b0, 0, 32'hFFFF_FFFF));
        foreach (dir_rows[k]) send_word(dir_rows[k]);
        i_in_valid <= 1'b0;

        // Joint count sweep, extremes included; all entries are loaded by now.
        set_joints(4'd8);
        send_word(mk(CMD_START, 3'd0, 0, 0, 1'b0, 32'd20000, 0));
        repeat (3) send_word(mk(CMD_TICK, 3'd0, 0, 0, 1'b0, 0, 32'd8000));
        i_in_valid <= 1'b0;
        set_joints(4'd0);
        send_word(mk(CMD_TICK, 3'd0, 0, 0, 1'b0, 0, 32'd8000));
        send_word(mk(CMD_START, 3'd0, 0, 0, 1'b0, 32'd20000, 0));
        send_word(mk(CMD_TICK, 3'd0, 0, 0, 1'b0, 0, 32'd8000));
        i_in_valid <= 1'b0;
        set_joints(4'd15);
        send_word(mk(CMD_TICK, 3'd0, 0, 0, 1'b0, 0, 32'd8000));
        i_in_valid <= 1'b0;

        // Random part: mostly move sequences with random content.
        stall_mode = 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            i_in_valid <= 1'b0;
            set_joints(4'($urandom_range(1, 8)));
            n = 0;
            while (n < 18) begin
                case ($urandom_range(0, 9))
                    0, 1: w = mk(CMD_LOAD, 3'($urandom), rnd_pos(), rnd_pos(),
                                 1'($urandom), $urandom, $urandom);
                    2: w = mk(CMD_START, 3'($urandom), $urandom, $urandom,
                              1'($urandom), rnd_time(), $urandom);
                    3: w = mk(CMD_NONE, 3'($urandom), $urandom, $urandom,
                              1'($urandom), $urandom, $urandom);
                    default: w = mk(CMD_TICK, 3'($urandom), $urandom, $urandom,
                                    1'($urandom), $urandom, rnd_time());
                endcase
                send_word(w);
                if (w.cmd != CMD_NONE) n++;
                if (n == 12 && phase == 1) begin
                    i_in_valid <= 1'b0;
                    while (pending_words.size() != 0) @(posedge i_clk);
                end
            end
        end
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (800) @(posedge i_clk);
        if (n_err == 0 && pending_words.size() == 0)
            $display("PASS joint_trajectory_smoothstep");
        else
            $display("FAIL joint_trajectory_smoothstep");
        $finish;
    end

endmodule
